[src/sfvb_pkg.sv]
// Shared types and constants for the stereo fade, volume and balance block.
// No dependencies; every other file of the block imports this package.
package sfvb_pkg;

  // Command codes carried in the cmd field.
  localparam logic [2:0] CMD_FRAME  = 3'd0;
  localparam logic [2:0] CMD_UP     = 3'd1;
  localparam logic [2:0] CMD_DOWN   = 3'd2;
  localparam logic [2:0] CMD_PAUSE  = 3'd3;
  localparam logic [2:0] CMD_RESUME = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_BALANCE      = 2'd0;
  localparam logic [1:0] REG_BLOCK_FRAMES = 2'd1;
  localparam logic [1:0] REG_LEVEL_STEP   = 2'd2;
  localparam logic [1:0] REG_START_TARGET = 2'd3;

  // Field widths and fixed values.
  localparam int         BF_W        = 13;
  localparam logic [7:0] LEVEL_FULL  = 8'd200;
  localparam int         QUEUE_DEPTH = 4;
  localparam int         QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic [7:0]         level_now;
    logic               is_paused;
  } out_item_t;

  // Configuration seen by the front and the back.
  typedef struct packed {
    logic signed [15:0] balance;
    logic [BF_W-1:0]    block_frames;
    logic [7:0]         level_step;
  } cfg_t;

  // One classified frame, handed from the front to the back.
  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [14:0]        gain;
    logic [7:0]         level;
    logic               paused;
  } work_t;

  // Q15 volume gain for each level: min(32767, level*32768/200).
  typedef logic [14:0] gain_tbl_t [256];

  function automatic gain_tbl_t build_gain_tbl();
    gain_tbl_t t;
    int        v;
    for (int i = 0; i < 256; i++) begin
      v = (i * 32768) / LEVEL_FULL;
      t[i] = (v > 32767) ? 15'h7fff : v[14:0];
    end
    return t;
  endfunction

  localparam gain_tbl_t GAIN_TBL = build_gain_tbl();

endpackage

[src/sfvb_front.sv]
// Front part: accepts items, runs the level, fade and pause control, and
// hands each frame with its gain to the queue. Depends on sfvb_pkg.
module sfvb_front #(
  parameter int MAX_BLOCK_FRAMES = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sfvb_pkg::in_item_t in_data,
  input  sfvb_pkg::cfg_t    cfg,
  input  logic              tgt_load,
  input  logic [7:0]        tgt_value,
  input  logic              q_full,
  output logic              q_push,
  output sfvb_pkg::work_t   q_data
);
  import sfvb_pkg::*;

  localparam int CNT_W = $clog2(MAX_BLOCK_FRAMES + 1);
  localparam int XW    = (CNT_W > BF_W) ? CNT_W : BF_W;

  logic [7:0]       level_r, level_nxt;
  logic [7:0]       target_r, target_nxt;
  logic             fading_r, fading_nxt;
  logic             paused_r, paused_nxt;
  logic [CNT_W-1:0] fib_r, fib_nxt;

  logic [XW-1:0]    bf_x, blk_x;
  logic [CNT_W-1:0] blk, fib_eff, fib_plus;
  logic [7:0]       step;
  logic [8:0]       up_sum;
  logic             accept;

  // Effective block length and command step, both clamped.
  always_comb begin
    bf_x  = XW'(cfg.block_frames);
    if (bf_x == '0) begin
      blk_x = XW'(1);
    end else if (bf_x > XW'(MAX_BLOCK_FRAMES)) begin
      blk_x = XW'(MAX_BLOCK_FRAMES);
    end else begin
      blk_x = bf_x;
    end
    blk  = blk_x[CNT_W-1:0];
    step = (cfg.level_step > LEVEL_FULL) ? LEVEL_FULL : cfg.level_step;
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Control update for one accepted item.
  always_comb begin
    level_nxt  = level_r;
    target_nxt = target_r;
    fading_nxt = fading_r;
    paused_nxt = paused_r;
    fib_nxt    = fib_r;
    q_push     = 1'b0;
    fib_eff    = (fib_r >= blk) ? '0 : fib_r;
    fib_plus   = fib_eff + CNT_W'(1);
    up_sum     = {1'b0, level_r} + {1'b0, step};

    if (accept) begin
      unique case (in_data.cmd)
        CMD_UP: begin
          if (!paused_r) begin
            level_nxt  = (up_sum > {1'b0, LEVEL_FULL}) ? LEVEL_FULL : up_sum[7:0];
            target_nxt = level_nxt;
          end
        end
        CMD_DOWN: begin
          if (!paused_r) begin
            level_nxt  = (level_r > step) ? level_r - step : 8'd0;
            target_nxt = level_nxt;
          end
        end
        CMD_PAUSE: begin
          if (!paused_r) begin
            fading_nxt = 1'b1;
            target_nxt = level_r;
          end
        end
        CMD_RESUME: begin
          if (paused_r) begin
            paused_nxt = 1'b0;
            fading_nxt = 1'b0;
            fib_nxt    = '0;
          end
        end
        CMD_FRAME: begin
          q_push = 1'b1;
          // One fade step on the first frame of each block.
          if (!paused_r && fib_eff == '0) begin
            if (fading_r) begin
              if (level_r != 8'd0) begin
                level_nxt = level_r - 8'd1;
              end else begin
                paused_nxt = 1'b1;
                fading_nxt = 1'b0;
              end
            end else if (level_r < target_r) begin
              level_nxt = level_r + 8'd1;
            end
          end
          fib_nxt = (fib_plus >= blk) ? '0 : fib_plus;
        end
        default: begin
        end
      endcase
    end

    // A start target write reloads the target; idle-only is user's duty.
    if (tgt_load) begin
      target_nxt = (tgt_value > LEVEL_FULL) ? LEVEL_FULL : tgt_value;
    end
  end

  // Frame record for the back part.
  always_comb begin
    q_data.left   = in_data.left_in;
    q_data.right  = in_data.right_in;
    q_data.gain   = GAIN_TBL[level_nxt];
    q_data.level  = paused_nxt ? 8'd0 : level_nxt;
    q_data.paused = paused_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= 8'd0;
      target_r <= 8'd100;
      fading_r <= 1'b0;
      paused_r <= 1'b0;
      fib_r    <= '0;
    end else begin
      level_r  <= level_nxt;
      target_r <= target_nxt;
      fading_r <= fading_nxt;
      paused_r <= paused_nxt;
      fib_r    <= fib_nxt;
    end
  end

  // The level and the target stay within full scale.
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LEVEL_FULL && target_r <= LEVEL_FULL)
    else $error("level or target above full scale");

  // Paused means silent and no fade running.
  a_paused_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    paused_r |-> (level_r == 8'd0 && !fading_r))
    else $error("paused with nonzero level or active fade");

  // Outside commands, a frame moves the level by at most one step.
  a_fade_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.cmd == CMD_FRAME) |=>
      (level_r == $past(level_r) || level_r == $past(level_r) + 8'd1 ||
       level_r == $past(level_r) - 8'd1))
    else $error("fade moved the level by more than one step");

endmodule

[src/sfvb_queue.sv]
// Short queue of frame records between the front and the back parts.
// Depends on sfvb_pkg for the record type and the depth.
module sfvb_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sfvb_pkg::work_t push_data,
  input  logic            pop,
  output sfvb_pkg::work_t pop_data,
  output logic            full,
  output logic            not_empty
);
  import sfvb_pkg::*;

  work_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full      = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // The fill count never passes the depth, and pops only come when not empty.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QPTR_W+1)'(QUEUE_DEPTH) && !(pop && !not_empty))
    else $error("queue overflow or pop from empty queue");

endmodule

[src/sfvb_back.sv]
// Back part: scales each frame by its volume gain with saturation, applies
// the balance gain and holds the result item. Depends on sfvb_pkg.
module sfvb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  sfvb_pkg::cfg_t     cfg,
  input  logic               q_not_empty,
  input  sfvb_pkg::work_t    q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output sfvb_pkg::out_item_t out_data
);
  import sfvb_pkg::*;

  logic        adv;

  // Stage A: volume products.
  logic               a_v_r;
  logic signed [31:0] a_l_r, a_r_r;
  logic [7:0]         a_level_r;
  logic               a_paused_r;

  // Stage B: balance products.
  logic               b_v_r;
  logic signed [33:0] b_l_r, b_r_r;
  logic [7:0]         b_level_r;
  logic               b_paused_r;

  // Output register.
  logic      out_v_r;
  out_item_t out_r;

  logic signed [15:0] gain_s;
  logic signed [31:0] l_sh, r_sh;
  logic signed [15:0] l_sat, r_sat;
  logic [16:0]        lg, rg;
  logic signed [33:0] l_rnd, r_rnd;
  logic signed [33:0] l_q, r_q;

  // The whole pipe moves whenever the output register is free or drains.
  assign adv       = !out_v_r || out_ready;
  assign q_pop     = q_not_empty && adv;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Balance gains in Q15: positive balance cuts left, negative cuts right.
  always_comb begin
    lg = 17'd32768 - ((cfg.balance > 16'sd0) ? {1'b0, cfg.balance} : 17'd0);
    rg = (cfg.balance < 16'sd0) ? ({cfg.balance[15], cfg.balance} + 17'd32768)
                                : 17'd32768;
  end

  // Floor shift by 14 and saturate to a sample.
  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [31:0] s;
    s = v >>> 14;
    if (s > 32'sd32767) begin
      return 16'sh7fff;
    end else if (s < -32'sd32768) begin
      return -16'sh8000;
    end
    return s[15:0];
  endfunction

  assign gain_s = $signed({1'b0, q_data.gain});
  assign l_sh   = a_l_r;
  assign r_sh   = a_r_r;
  assign l_sat  = sat16(l_sh);
  assign r_sat  = sat16(r_sh);

  // Q15 divide truncating toward zero.
  always_comb begin
    l_rnd = b_l_r + (b_l_r[33] ? 34'sd32767 : 34'sd0);
    r_rnd = b_r_r + (b_r_r[33] ? 34'sd32767 : 34'sd0);
    l_q   = l_rnd >>> 15;
    r_q   = r_rnd >>> 15;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r   <= q_pop;
      b_v_r   <= a_v_r;
      out_v_r <= b_v_r;
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    if (adv) begin
      a_l_r      <= q_data.left * gain_s;
      a_r_r      <= q_data.right * gain_s;
      a_level_r  <= q_data.level;
      a_paused_r <= q_data.paused;

      b_l_r      <= l_sat * $signed({1'b0, lg});
      b_r_r      <= r_sat * $signed({1'b0, rg});
      b_level_r  <= a_level_r;
      b_paused_r <= a_paused_r;

      out_r.left_out  <= b_paused_r ? 16'sd0 : l_q[15:0];
      out_r.right_out <= b_paused_r ? 16'sd0 : r_q[15:0];
      out_r.level_now <= b_level_r;
      out_r.is_paused <= b_paused_r;
    end
  end

  // A paused frame leaves as silence at level zero.
  a_paused_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.is_paused) |->
      (out_r.left_out == 16'sd0 && out_r.right_out == 16'sd0 &&
       out_r.level_now == 8'd0))
    else $error("paused result is not silent");

endmodule

[src/stereo_fade_volume_balance.sv]
// Top level of the stereo fade, volume and balance block: configuration
// registers, front control, frame queue and scaling back end.
// Depends on sfvb_pkg, sfvb_front, sfvb_queue and sfvb_back.
//
//   Port group | Direction | Carries
//   in_*       | input     | command or stereo frame (in_item_t)
//   out_*      | output    | scaled frame, level and pause flag (out_item_t)
//   cfg_*      | input     | register index and write data
//
// One item is accepted per cycle while the four-entry queue has room.
// After acceptance a frame's result passes through the queue, the volume
// multiply stage, the balance multiply stage and the output register before
// it is valid. Commands other than frames produce no result.
// Reset is synchronous and active low and clears all control state.
// A stall at the output freezes the back pipe; the queue then fills and
// lowers in_ready.
module stereo_fade_volume_balance #(
  parameter int MAX_BLOCK_FRAMES = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sfvb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sfvb_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import sfvb_pkg::*;

  logic signed [15:0] balance_r;
  logic [BF_W-1:0]    block_frames_r;
  logic [7:0]         level_step_r;
  logic               cfg_wr;
  logic               tgt_load;
  cfg_t               cfg;

  logic  q_push, q_pop, q_full, q_not_empty;
  work_t q_in, q_out;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign tgt_load  = cfg_wr && (cfg_index == REG_START_TARGET);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      balance_r      <= 16'sd0;
      block_frames_r <= BF_W'(1024);
      level_step_r   <= 8'd20;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_BALANCE:      balance_r      <= $signed(cfg_data);
        REG_BLOCK_FRAMES: block_frames_r <= cfg_data[BF_W-1:0];
        REG_LEVEL_STEP:   level_step_r   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.balance      = balance_r;
    cfg.block_frames = block_frames_r;
    cfg.level_step   = level_step_r;
  end

  sfvb_front #(
    .MAX_BLOCK_FRAMES(MAX_BLOCK_FRAMES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg),
    .tgt_load  (tgt_load),
    .tgt_value (cfg_data[7:0]),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  sfvb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  sfvb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_data      (q_out),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

[tb/stereo_fade_volume_balance_checker.sv]
`timescale 1ns / 1ps
// Result checker for stereo_fade_volume_balance: follows the register, item
// and result channels, predicts each frame's result and compares it.
// Depends on sfvb_pkg for the item types, command codes and register indexes.
module stereo_fade_volume_balance_checker #(
  parameter int BLOCK_CAP = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  sfvb_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  sfvb_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output int                  fail_count,
  output int                  frames_pending,
  output int                  frames_checked,
  output int                  silent_frames
);
  import sfvb_pkg::*;

  // Register copies.
  logic signed [15:0] bal;
  logic [BF_W-1:0]    blk_len;
  logic [7:0]         vol_step;
  logic [7:0]         first_target;

  // Fade and pause state.
  logic [7:0] lvl;
  logic [7:0] tgt;
  bit         fading;
  bit         silent;
  int         blk_pos;

  // Results still owed by the block, oldest first.
  out_item_t frames_due[$];

  task automatic note_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  function automatic logic [7:0] cap_level(input int v);
    return (v > int'(LEVEL_FULL)) ? LEVEL_FULL : v[7:0];
  endfunction

  // Volume scaling with a floor shift and saturation, then the balance
  // gain, which truncates toward zero.
  function automatic logic signed [15:0] scale_sample(input logic signed [15:0] x,
                                                      input int gain, input int bal_gain);
    longint p;
    p = (longint'(x) * gain) >>> 14;
    if (p > 32767) p = 32767;
    else if (p < -32768) p = -32768;
    p = (p * bal_gain) / 32768;
    return p[15:0];
  endfunction

  task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
    case (idx)
      REG_BALANCE: bal = val;
      REG_BLOCK_FRAMES: blk_len = val[BF_W-1:0];
      REG_LEVEL_STEP: vol_step = val[7:0];
      REG_START_TARGET: begin
        first_target = val[7:0];
        tgt = cap_level(int'(first_target));
      end
      default: ;
    endcase
  endtask

  // Apply one accepted item to the fade state; a frame also yields a result.
  task automatic fade_and_scale(input in_item_t it);
    int        step;
    int        len;
    int        gain;
    int        lg;
    int        rg;
    out_item_t res;
    step = int'(cap_level(int'(vol_step)));
    case (it.cmd)
      CMD_UP: begin
        if (!silent) begin
          lvl = cap_level(int'(lvl) + step);
          tgt = lvl;
        end
      end
      CMD_DOWN: begin
        if (!silent) begin
          lvl = (int'(lvl) > step) ? 8'(int'(lvl) - step) : 8'd0;
          tgt = lvl;
        end
      end
      CMD_PAUSE: begin
        if (!silent) begin
          fading = 1'b1;
          tgt = lvl;
        end
      end
      CMD_RESUME: begin
        if (silent) begin
          silent = 1'b0;
          fading = 1'b0;
          blk_pos = 0;
        end
      end
      CMD_FRAME: begin
        len = (blk_len == 0) ? 1 : ((int'(blk_len) > BLOCK_CAP) ? BLOCK_CAP : int'(blk_len));
        if (blk_pos >= len) blk_pos = 0;
        // One fade step on the first frame of each block.
        if (!silent && blk_pos == 0) begin
          if (fading) begin
            if (lvl > 0) begin
              lvl = lvl - 8'd1;
            end else begin
              silent = 1'b1;
              fading = 1'b0;
            end
          end else if (lvl < tgt) begin
            lvl = lvl + 8'd1;
          end
        end
        blk_pos++;
        if (blk_pos >= len) blk_pos = 0;

        res = '0;
        if (silent) begin
          res.is_paused = 1'b1;
        end else begin
          gain = (int'(lvl) * 32768) / int'(LEVEL_FULL);
          if (gain > 32767) gain = 32767;
          lg = 32768 - ((bal > 0) ? int'(bal) : 0);
          rg = 32768 + ((bal < 0) ? int'(bal) : 0);
          res.left_out = scale_sample(it.left_in, gain, lg);
          res.right_out = scale_sample(it.right_in, gain, rg);
          res.level_now = lvl;
        end
        frames_due.push_back(res);
      end
      default: ;
    endcase
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (frames_due.size() == 0) begin
      note_mismatch($sformatf("result with no frame pending: left %0d right %0d level %0d",
                              got.left_out, got.right_out, got.level_now));
    end else begin
      want = frames_due.pop_front();
      frames_checked++;
      if (want.is_paused) silent_frames++;
      if (got.left_out !== want.left_out)
        note_mismatch($sformatf("frame %0d left_out %0d, expected %0d",
                                frames_checked, got.left_out, want.left_out));
      if (got.right_out !== want.right_out)
        note_mismatch($sformatf("frame %0d right_out %0d, expected %0d",
                                frames_checked, got.right_out, want.right_out));
      if (got.level_now !== want.level_now)
        note_mismatch($sformatf("frame %0d level_now %0d, expected %0d",
                                frames_checked, got.level_now, want.level_now));
      if (got.is_paused !== want.is_paused)
        note_mismatch($sformatf("frame %0d is_paused %0b, expected %0b",
                                frames_checked, got.is_paused, want.is_paused));
    end
  endtask

  // All three channels are sampled at the clock edge that accepts them.
  always @(posedge clk) begin
    if (!rst_n) begin
      bal = '0;
      blk_len = BF_W'(1024);
      vol_step = 8'd20;
      first_target = 8'd100;
      lvl = '0;
      tgt = 8'd100;
      fading = 1'b0;
      silent = 1'b0;
      blk_pos = 0;
      frames_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (in_valid && in_ready) fade_and_scale(in_data);
      if (out_valid && out_ready) check_result(out_data);
    end
    frames_pending <= frames_due.size();
  end

endmodule

[tb/stereo_fade_volume_balance_tb.sv]
`timescale 1ns / 1ps
// Testbench top for stereo_fade_volume_balance: clock, reset, stimulus,
// output stalls and the verdict. Depends on sfvb_pkg, the block and the checker.
module stereo_fade_volume_balance_tb;
  import sfvb_pkg::*;

  localparam int BLOCK_CAP   = 4096;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 250;
  localparam int LONG_HOLD   = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  in_item_t    in_data = '0;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_ready;
  logic        out_valid;
  logic        cfg_ready;
  out_item_t   out_data;

  int fail_count;
  int frames_pending;
  int frames_checked;
  int silent_frames;

  // Idling controls for the sender and the receiver.
  bit src_gaps;
  bit sink_stalls;
  bit hold_req;

  always #10 clk = ~clk;

  stereo_fade_volume_balance #(
    .MAX_BLOCK_FRAMES(BLOCK_CAP)
  ) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  stereo_fade_volume_balance_checker #(
    .BLOCK_CAP(BLOCK_CAP)
  ) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count), .frames_pending(frames_pending),
    .frames_checked(frames_checked), .silent_frames(silent_frames)
  );

  // Safety net far above the slowest legal run.
  initial begin
    #10_000_000;
    $display("stereo_fade_volume_balance_tb failed");
    $finish;
  end

  // Result receiver: random stalls, or one long hold-off on request.
  initial begin : sink
    int wait_cycles;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        wait_cycles = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        wait_cycles = sink_stalls ? $urandom_range(0, 10) : 0;
      end
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Offer one item after an optional gap; returns at the accepting edge.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = src_gaps ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // Wait until every frame has come back, then let the block idle.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (frames_pending != 0);
    repeat (12) @(posedge clk);
  endtask

  function automatic in_item_t pack_item(input logic [2:0] c, input logic [15:0] l,
                                         input logic [15:0] r);
    in_item_t it;
    it.cmd = c;
    it.left_in = l;
    it.right_in = r;
    return it;
  endfunction

  // Samples lean toward full scale, zero and minus one.
  function automatic logic [15:0] random_sample();
    int pick;
    pick = $urandom_range(0, 15);
    case (pick)
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly frames, with volume steps, pauses, resumes and a few unknown codes.
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 78) it.cmd = CMD_FRAME;
    else if (pick < 83) it.cmd = CMD_UP;
    else if (pick < 89) it.cmd = CMD_DOWN;
    else if (pick < 92) it.cmd = CMD_PAUSE;
    else if (pick < 98) it.cmd = CMD_RESUME;
    else it.cmd = 3'($urandom_range(5, 7));
    it.left_in = random_sample();
    it.right_in = random_sample();
    return it;
  endfunction

  // Fixed corner settings first, then random ones with short blocks.
  task automatic apply_settings(input int k);
    logic [15:0] bal;
    logic [15:0] blk;
    logic [15:0] step;
    logic [15:0] target;
    case (k)
      0: begin
        bal = 16'h0000; blk = 16'd1; step = 16'd20; target = 16'd100;
      end
      1: begin
        bal = 16'h7fff; blk = 16'd2; step = 16'd0; target = 16'd200;
      end
      2: begin
        bal = 16'h8000; blk = 16'd0; step = 16'd255; target = 16'd255;
      end
      3: begin
        bal = 16'h8001; blk = 16'h1fff; step = 16'd200; target = 16'd0;
      end
      default: begin
        bal = 16'($urandom);
        blk = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 64))
                                          : 16'($urandom_range(1, 3));
        step = 16'($urandom_range(0, 255));
        target = 16'($urandom_range(0, 255));
      end
    endcase
    write_reg(REG_BALANCE, bal);
    write_reg(REG_BLOCK_FRAMES, blk);
    write_reg(REG_LEVEL_STEP, step);
    write_reg(REG_START_TARGET, target);
  endtask

  initial begin : stimulus
    int       sent;
    in_item_t it;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    src_gaps = 1'b1;
    sink_stalls = 1'b1;

    // Directed opening: one-frame blocks and full-range volume steps.
    write_reg(REG_BALANCE, 16'h0000);
    write_reg(REG_BLOCK_FRAMES, 16'd1);
    write_reg(REG_LEVEL_STEP, 16'd200);
    write_reg(REG_START_TARGET, 16'd200);
    send_item(pack_item(CMD_FRAME, 16'h7fff, 16'h8000));
    send_item(pack_item(CMD_FRAME, 16'hffff, 16'h0001));
    // Full volume doubles the sample and saturates.
    send_item(pack_item(CMD_UP, 16'h0000, 16'h0000));
    send_item(pack_item(CMD_FRAME, 16'h7fff, 16'h8000));
    send_item(pack_item(CMD_FRAME, 16'h4000, 16'hc000));
    send_item(pack_item(CMD_DOWN, 16'h0000, 16'h0000));
    send_item(pack_item(CMD_FRAME, 16'h1234, 16'h5678));
    // Fade out, with a resume and unknown codes that must be ignored.
    send_item(pack_item(CMD_UP, 16'h0000, 16'h0000));
    send_item(pack_item(CMD_PAUSE, 16'h0000, 16'h0000));
    send_item(pack_item(CMD_FRAME, 16'h7fff, 16'h8000));
    send_item(pack_item(CMD_RESUME, 16'h0000, 16'h0000));
    send_item(pack_item(3'd5, 16'hffff, 16'hffff));
    send_item(pack_item(3'd7, 16'hffff, 16'hffff));
    send_item(pack_item(CMD_DOWN, 16'h0000, 16'h0000));
    // The frame that enters the paused state is already silent.
    send_item(pack_item(CMD_FRAME, 16'h7fff, 16'h7fff));
    send_item(pack_item(CMD_UP, 16'h0000, 16'h0000));
    send_item(pack_item(CMD_PAUSE, 16'h0000, 16'h0000));
    send_item(pack_item(CMD_FRAME, 16'h8000, 16'h8000));
    send_item(pack_item(CMD_RESUME, 16'h0000, 16'h0000));
    send_item(pack_item(CMD_FRAME, 16'h0100, 16'hff00));
    send_item(pack_item(CMD_UP, 16'h0000, 16'h0000));
    send_item(pack_item(CMD_FRAME, 16'h8000, 16'h7fff));
    send_item(pack_item(CMD_FRAME, 16'h7fff, 16'h8000));

    // Random phases, each under its own register setting and idling mix.
    for (int k = 0; k < PHASES; k++) begin
      settle();
      apply_settings(k);
      src_gaps = (k % 3) == 0;
      sink_stalls = (k % 3) != 1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        it = random_item();
        send_item(it);
        if (it.cmd <= CMD_RESUME) begin
          sent++;
          // Hold the output off while items keep coming, to fill the queue.
          if (k == 4 && sent == 60) hold_req = 1'b1;
        end
      end
    end
    settle();

    $display("Run summary: %0d frame results checked, %0d of them silent while paused,",
             frames_checked, silent_frames);
    $display("over %0d register settings, random idling and one %0d-cycle output hold-off.",
             PHASES + 1, LONG_HOLD);
    if (fail_count == 0 && frames_pending == 0) begin
      $display("stereo_fade_volume_balance_tb passed");
    end else begin
      $display("stereo_fade_volume_balance_tb failed");
    end
    $finish;
  end

endmodule

[files.f]
src/sfvb_pkg.sv
src/sfvb_front.sv
src/sfvb_queue.sv
src/sfvb_back.sv
src/stereo_fade_volume_balance.sv
tb/stereo_fade_volume_balance_checker.sv
tb/stereo_fade_volume_balance_tb.sv
